/* rtl/core/fts_pkg.sv */
// ============================================================================
// fts_pkg
// Shared types and constants for the fade transition sequencer.
// ============================================================================
`default_nettype none

package fts_pkg;

    localparam int DELTA_W  = 20;
    localparam int LENGTH_W = 24;
    localparam int ELAPS_W  = 25;
    localparam int HOLD_W   = 8;
    localparam int LEVEL_W  = 17;
    localparam int QUOT_W   = 16;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;

    localparam int DIV_STEPS = QUOT_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_SCENE = 2'd2,
        CMD_SKIP  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_OUT  = 2'd1,
        PH_CHG  = 2'd2,
        PH_IN   = 2'd3
    } t_phase;

    localparam logic [LEVEL_W-1:0]  ONE_Q16    = LEVEL_W'(65536);
    localparam logic [LENGTH_W-1:0] SPAN_RESET = LENGTH_W'(1000000);
    localparam logic [HOLD_W-1:0]   HOLD_RESET = HOLD_W'(3);
    localparam logic [HOLD_W-1:0]   HOLD_MAX   = '1;
    localparam logic [ELAPS_W-1:0]  ELAPS_MAX  = '1;

    typedef struct packed {
        logic apply;
        logic div_init;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

endpackage

`default_nettype wire

/* rtl/core/fts_ctrl.sv */
// ============================================================================
// fts_ctrl
// Sequencing controller: accepts a word, runs the divider steps and loads
// the result word into the output register.
// ============================================================================
`default_nettype none

module fts_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output fts_pkg::t_dp_cmd     o_cmd
);
    import fts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [STEP_W-1:0]   r_step;
    logic                r_out_valid;
    logic                out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    assign o_cmd.apply    = i_in_valid && (r_state == S_IDLE);
    assign o_cmd.div_init = (r_state == S_PREP);
    assign o_cmd.div_step = (r_state == S_DIV);
    assign o_cmd.load_out = (r_state == S_OUT) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/fts_dpath.sv */
// ============================================================================
// fts_dpath
// Sequencer state, command update, bit-serial ratio divider and result
// formatting.
// ============================================================================
`default_nettype none

module fts_dpath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire fts_pkg::t_dp_cmd                i_cmd,
    input  wire logic                            i_cfg_wen,
    input  wire logic [fts_pkg::HOLD_W-1:0]      i_cfg_wdata,
    input  wire logic [1:0]                      i_op,
    input  wire logic [fts_pkg::DELTA_W-1:0]     i_delta_us,
    input  wire logic                            i_with_fade,
    input  wire logic [fts_pkg::LENGTH_W-1:0]    i_length_us,
    output logic [fts_pkg::M_TDATA_W-1:0]        o_result
);
    import fts_pkg::*;

    logic [HOLD_W-1:0]   r_hold_ticks;
    t_phase              r_phase;
    logic [ELAPS_W-1:0]  r_elapsed;
    logic [LENGTH_W-1:0] r_span;
    logic [HOLD_W-1:0]   r_hold_count;
    logic                r_kind;
    logic                r_overlay;

    t_phase              n_phase;
    logic [ELAPS_W-1:0]  n_elapsed;
    logic [LENGTH_W-1:0] n_span;
    logic [HOLD_W-1:0]   n_hold_count;
    logic                n_kind;
    logic                n_overlay;

    logic [ELAPS_W:0]    sum;
    logic [ELAPS_W-1:0]  sat;
    logic                at_span;
    logic [HOLD_W-1:0]   hold_inc;

    logic [LENGTH_W-1:0] r_rem;
    logic [QUOT_W-1:0]   r_quot;
    logic                r_full;
    logic [LENGTH_W:0]   shifted;
    logic                fits;

    logic [LEVEL_W-1:0]  ratio;
    logic [LEVEL_W-1:0]  level;
    logic [LEVEL_W-1:0]  gain;
    logic [M_TDATA_W-1:0] r_result;

    assign sum      = {1'b0, r_elapsed} + (ELAPS_W + 1)'(i_delta_us);
    assign sat      = sum[ELAPS_W] ? ELAPS_MAX : sum[ELAPS_W-1:0];
    assign at_span  = (sat >= ELAPS_W'(r_span));
    assign hold_inc = (r_hold_count < HOLD_MAX) ? r_hold_count + 1'b1 : r_hold_count;

    always_comb begin
        n_phase      = r_phase;
        n_elapsed    = r_elapsed;
        n_span       = r_span;
        n_hold_count = r_hold_count;
        n_kind       = r_kind;
        n_overlay    = r_overlay;
        case (t_cmd'(i_op))
            CMD_TICK: begin
                if (r_phase != PH_IDLE) begin
                    n_elapsed = sat;
                    if (r_phase == PH_OUT && at_span) begin
                        n_elapsed    = ELAPS_W'(r_span);
                        n_hold_count = hold_inc;
                        if (hold_inc >= r_hold_ticks) begin
                            n_phase = PH_CHG;
                        end
                    end else if (r_phase == PH_IN && at_span) begin
                        n_phase      = PH_IDLE;
                        n_elapsed    = '0;
                        n_hold_count = '0;
                        n_overlay    = 1'b0;
                    end
                end
            end
            CMD_START: begin
                n_kind       = i_with_fade;
                n_span       = i_length_us;
                n_elapsed    = '0;
                n_hold_count = '0;
                n_phase      = i_with_fade ? PH_OUT : PH_CHG;
                n_overlay    = i_with_fade;
            end
            CMD_SCENE: begin
                n_elapsed    = '0;
                n_hold_count = '0;
                n_phase      = r_kind ? PH_IN : PH_IDLE;
                n_overlay    = r_kind;
            end
            default: begin
                n_phase      = PH_IDLE;
                n_elapsed    = '0;
                n_hold_count = '0;
                n_overlay    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks <= HOLD_RESET;
            r_phase      <= PH_IDLE;
            r_elapsed    <= '0;
            r_span       <= SPAN_RESET;
            r_hold_count <= '0;
            r_kind       <= 1'b0;
            r_overlay    <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_hold_ticks <= i_cfg_wdata;
            end
            if (i_cmd.apply) begin
                r_phase      <= n_phase;
                r_elapsed    <= n_elapsed;
                r_span       <= n_span;
                r_hold_count <= n_hold_count;
                r_kind       <= n_kind;
                r_overlay    <= n_overlay;
            end
        end
    end

    // Restoring division of elapsed * 2^16 by span, one quotient bit a cycle.
    // The remainder starts at elapsed, which is below span when divided.
    assign shifted = {r_rem, 1'b0};
    assign fits    = (shifted >= {1'b0, r_span});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_full <= (r_span == '0) || (r_elapsed >= ELAPS_W'(r_span));
            r_rem  <= r_elapsed[LENGTH_W-1:0];
            r_quot <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= fits ? LENGTH_W'(shifted - {1'b0, r_span}) : shifted[LENGTH_W-1:0];
            r_quot <= {r_quot[QUOT_W-2:0], fits};
        end
    end

    assign ratio = r_full ? ONE_Q16 : {1'b0, r_quot};

    always_comb begin
        case (r_phase)
            PH_OUT:  level = ratio;
            PH_CHG:  level = ONE_Q16;
            PH_IN:   level = ONE_Q16 - ratio;
            default: level = '0;
        endcase
        case (r_phase)
            PH_IDLE: gain = ONE_Q16;
            PH_CHG:  gain = '0;
            default: gain = ONE_Q16 - level;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_result <= {1'b0,
                         (r_phase == PH_OUT) || (r_phase == PH_CHG),
                         r_phase == PH_CHG,
                         r_overlay,
                         gain,
                         level,
                         r_phase};
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

/* rtl/core/fade_transition_sequencer.sv */
// ============================================================================
// fade_transition_sequencer
// Fade-out, hold and fade-in sequencer with a bit-serial level divider.
// ============================================================================
// Each input word is a command (tick, start, scene changed, skip) that
// updates the sequencer state and yields exactly one result word with the
// phase, the darkness level, the audio gain and three flags. The command is
// applied at the edge that accepts the word. The divider is then set up,
// the restoring divider forms elapsed/span one quotient bit a cycle, and the
// result is loaded into the result register once the output is free. A new
// word is accepted only when the last one is through, once its result is
// loaded, even while that result still waits downstream. The user must
// write the hold_ticks register through i_cfg_wen only while idle; the
// block itself does not enforce this.
`default_nettype none

module fade_transition_sequencer (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wen,
    input  wire logic [fts_pkg::HOLD_W-1:0]      i_cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // delta_us[19:0], length_us[43:20], zero pad
    input  wire logic [fts_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // cmd[1:0], with_fade[2]
    input  wire logic [fts_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // phase_now[1:0], fade_level[18:2], audio_gain[35:19], fade_on[36],
    // ready_to_switch[37], holds_updates[38], zero pad
    output logic [fts_pkg::M_TDATA_W-1:0]        m_axis_tdata
);
    import fts_pkg::*;

    t_dp_cmd dp_cmd;

    fts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (dp_cmd)
    );

    fts_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (s_axis_tuser[1:0]),
        .i_delta_us  (s_axis_tdata[DELTA_W-1:0]),
        .i_with_fade (s_axis_tuser[2]),
        .i_length_us (s_axis_tdata[DELTA_W+LENGTH_W-1:DELTA_W]),
        .o_result    (m_axis_tdata)
    );

endmodule

`default_nettype wire
